>>> design/differential_drive_odometry_unit_defines.svh
// Assertion macros used by the odometry checker file.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH

// Check a property on a given clock, disabled while the given reset is low.
`define DDO_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on clk_i, disabled during rst_ni.
`define DDO_ASSERT(name, prop, msg) \
  `DDO_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

>>> design/ddo_pkg.sv
// Package with the types and constants of the odometry unit.
package ddo_pkg;

  localparam int CordicSteps = 16;

  localparam logic [31:0] MptReset = 32'd658842;
  localparam logic [31:0] IwbReset = 32'd218453;
  // round(2^31 / pi): Q16.16 radians to binary angle
  localparam logic [31:0] RadToBam = 32'd683565276;
  // CORDIC start vector, inverse gain in Q2.30
  localparam logic [33:0] CordicX0 = 34'd652032874;
  localparam logic [31:0] UsPerSec = 32'd1000000;

  // register indexes
  localparam logic [7:0] RegMetersPerTick    = 8'd0;
  localparam logic [7:0] RegInverseWheelBase = 8'd1;

  localparam logic [31:0] AtanTab [30] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef enum logic [4:0] {
    S_IDLE,
    S_ML,
    S_MR,
    S_DIFF,
    S_T1,
    S_T2,
    S_DTH,
    S_DANG,
    S_CORD,
    S_PX1,
    S_PX2,
    S_PY1,
    S_PY2,
    S_VSEL,
    S_V1,
    S_V2,
    S_DIV,
    S_VSAT,
    S_DONE
  } state_e;

endpackage

>>> design/differential_drive_odometry_unit.sv
// Top level of the differential-drive wheel odometry unit.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one encoder sample: both
//   wheel tick counters and the microseconds since the previous sample.
//   Output channel (out_valid_o / out_stall_i) gives one pose and velocity
//   result per sample. Configuration writes go over cfg_valid_i/cfg_ready_o;
//   index 0 is meters_per_tick, index 1 inverse_wheel_base, others ignored.
//   When elapsed time is zero the velocity steps are skipped. One item is
//   in work at a time; the next can be accepted in the cycle after the
//   result enters the output register. The work is done by the shared
//   multiplier sequence, 16 CORDIC steps and two 64-step restoring
//   divisions for the velocities.
//   A finished result waits in the output register while the receiver
//   stalls; a new sample can be accepted meanwhile, and its result waits in
//   the datapath until the register frees up.
//   Reset clears pose, stored counters and returns registers to defaults.
module differential_drive_odometry_unit
  import ddo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] left_count_i,
  input  logic [31:0] right_count_i,
  input  logic [31:0] elapsed_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] linear_velocity_o,
  output logic signed [31:0] angular_velocity_o,
  output logic        velocity_valid_o
);

  localparam logic [5:0] CordLast = 6'(CordicSteps - 1);
  localparam logic [5:0] DivLast  = 6'd63;

  state_e state_q, state_d;

  logic [31:0] mpt_q, iwb_q;
  logic [31:0] prev_l_q, prev_r_q, x_acc_q, y_acc_q, ang_acc_q;
  logic [31:0] dlt_l_q, dlt_r_q, dt_q;
  logic signed [48:0] dl_q, dr_q, dist_q;
  logic [48:0] mag_q;
  logic        neg_q, big_q, sel_q;
  logic [65:0] t_q;
  logic [31:0] dth_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic        flip_q;
  logic [5:0]  cnt_q;
  logic [63:0] acc_q;
  logic [63:0] num_q;
  logic [32:0] rem_q;
  logic [31:0] lin_q, angv_q;

  logic        out_valid_q;
  logic [31:0] o_x_q, o_y_q, o_h_q, o_lin_q, o_ang_q;
  logic        o_vv_q;

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] mul_p;

  logic in_acc, load_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign load_out    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ML: begin
        mul_a = {{3{dlt_l_q[31]}}, dlt_l_q};
        mul_b = {3'b0, mpt_q};
      end
      S_MR: begin
        mul_a = {{3{dlt_r_q[31]}}, dlt_r_q};
        mul_b = {3'b0, mpt_q};
      end
      S_T1: begin
        mul_a = {10'b0, mag_q[48:24]};
        mul_b = {3'b0, iwb_q};
      end
      S_T2: begin
        mul_a = {11'b0, mag_q[23:0]};
        mul_b = {3'b0, iwb_q};
      end
      S_DANG: begin
        mul_a = {{3{dth_q[31]}}, dth_q};
        mul_b = {3'b0, RadToBam};
      end
      S_PX1: begin
        mul_a = {{10{dist_q[48]}}, dist_q[48:24]};
        mul_b = {cx_q[33], cx_q};
      end
      S_PX2: begin
        mul_a = {11'b0, dist_q[23:0]};
        mul_b = {cx_q[33], cx_q};
      end
      S_PY1: begin
        mul_a = {{10{dist_q[48]}}, dist_q[48:24]};
        mul_b = {cy_q[33], cy_q};
      end
      S_PY2: begin
        mul_a = {11'b0, dist_q[23:0]};
        mul_b = {cy_q[33], cy_q};
      end
      S_V1: begin
        mul_a = {13'b0, mag_q[43:22]};
        mul_b = {3'b0, UsPerSec};
      end
      S_V2: begin
        mul_a = {13'b0, mag_q[21:0]};
        mul_b = {3'b0, UsPerSec};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_ML;
      S_ML:   state_d = S_MR;
      S_MR:   state_d = S_DIFF;
      S_DIFF: state_d = S_T1;
      S_T1:   state_d = S_T2;
      S_T2:   state_d = S_DTH;
      S_DTH:  state_d = S_DANG;
      S_DANG: state_d = S_CORD;
      S_CORD: if (cnt_q == CordLast) state_d = S_PX1;
      S_PX1:  state_d = S_PX2;
      S_PX2:  state_d = S_PY1;
      S_PY1:  state_d = S_PY2;
      S_PY2:  state_d = (dt_q == '0) ? S_DONE : S_VSEL;
      S_VSEL: state_d = S_V1;
      S_V1:   state_d = S_V2;
      S_V2:   state_d = S_DIV;
      S_DIV:  if (cnt_q == DivLast) state_d = S_VSAT;
      S_VSAT: state_d = sel_q ? S_DONE : S_VSEL;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers, one step per state
  logic signed [49:0] sum50, diff50;
  logic signed [48:0] vsel;
  logic signed [33:0] xs, ys;
  logic signed [33:0] atan_s;
  logic signed [33:0] cx_n, cy_n, cz_n;
  logic [31:0] mid;
  logic [32:0] shl;
  logic [63:0] px_sum;
  logic [31:0] sat_v;

  always_comb begin
    sum50  = 50'(dl_q) + 50'(dr_q);
    diff50 = 50'(dr_q) - 50'(dl_q);
    vsel   = sel_q ? 49'(signed'(dth_q)) : dist_q;
    xs     = cx_q >>> cnt_q;
    ys     = cy_q >>> cnt_q;
    atan_s = {2'b0, AtanTab[cnt_q[4:0]]};
    // one CORDIC rotation step
    if (!cz_q[33]) begin
      cx_n = cx_q - ys;
      cy_n = cy_q + xs;
      cz_n = cz_q - atan_s;
    end else begin
      cx_n = cx_q + ys;
      cy_n = cy_q - xs;
      cz_n = cz_q + atan_s;
    end
    mid    = ang_acc_q + mul_p[48:17];
    shl    = {rem_q[31:0], num_q[63]};
    px_sum = acc_q + mul_p[63:0];
    if (neg_q) begin
      sat_v = (big_q || num_q > 64'h80000000) ? 32'h80000000 : 32'(0) - num_q[31:0];
    end else begin
      sat_v = (big_q || num_q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : num_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpt_q     <= MptReset;
      iwb_q     <= IwbReset;
      prev_l_q  <= '0;
      prev_r_q  <= '0;
      x_acc_q   <= '0;
      y_acc_q   <= '0;
      ang_acc_q <= '0;
      cnt_q     <= '0;
      sel_q     <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_valid_i) begin
        if (cfg_index_i == RegMetersPerTick) mpt_q <= cfg_data_i;
        if (cfg_index_i == RegInverseWheelBase) iwb_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            dlt_l_q  <= left_count_i - prev_l_q;
            dlt_r_q  <= right_count_i - prev_r_q;
            prev_l_q <= left_count_i;
            prev_r_q <= right_count_i;
            dt_q     <= elapsed_us_i;
          end
        end
        S_ML: dl_q <= mul_p[64:16];
        S_MR: dr_q <= mul_p[64:16];
        S_DIFF: begin
          dist_q <= sum50[49:1];
          neg_q  <= diff50[49];
          mag_q  <= diff50[49] ? 49'(-diff50) : diff50[48:0];
        end
        S_T1: t_q <= {mul_p[57:0], 8'b0};
        S_T2: t_q <= t_q + {26'b0, mul_p[55:16]};
        S_DTH: begin
          if (neg_q) begin
            dth_q <= (t_q > 66'h80000000) ? 32'h80000000 : 32'(0) - t_q[31:0];
          end else begin
            dth_q <= (t_q > 66'h7FFFFFFF) ? 32'h7FFFFFFF : t_q[31:0];
          end
        end
        S_DANG: begin
          // Step heading and fold the midpoint angle into the right half plane
          ang_acc_q <= ang_acc_q + mul_p[47:16];
          flip_q    <= (mid[31:30] == 2'b01) || (mid[31:30] == 2'b10);
          cz_q      <= 34'(signed'({~mid[31] ^ mid[30] ? mid[31] : ~mid[31], mid[30:0]}));
          cx_q      <= signed'(CordicX0);
          cy_q      <= '0;
          cnt_q     <= '0;
        end
        S_CORD: begin
          cz_q <= cz_n;
          if (cnt_q == CordLast) begin
            cnt_q <= '0;
            cx_q  <= flip_q ? -cx_n : cx_n;
            cy_q  <= flip_q ? -cy_n : cy_n;
          end else begin
            cx_q  <= cx_n;
            cy_q  <= cy_n;
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_PX1: acc_q <= {mul_p[39:0], 24'b0};
        S_PX2: x_acc_q <= x_acc_q + px_sum[61:30];
        S_PY1: acc_q <= {mul_p[39:0], 24'b0};
        S_PY2: begin
          y_acc_q <= y_acc_q + px_sum[61:30];
          sel_q   <= 1'b0;
          lin_q   <= '0;
          angv_q  <= '0;
        end
        S_VSEL: begin
          neg_q <= vsel[48];
          mag_q <= vsel[48] ? 49'(-vsel) : vsel;
          big_q <= vsel[48] ? (|(49'(-vsel) >> 44)) : (|vsel[47:44]);
        end
        S_V1: begin
          num_q <= {mul_p[41:0], 22'b0};
          rem_q <= '0;
          cnt_q <= '0;
        end
        S_V2: num_q <= num_q + {22'b0, mul_p[41:0]};
        S_DIV: begin
          // Restoring divide, one quotient bit per cycle
          if (shl >= {1'b0, dt_q}) begin
            rem_q <= shl - {1'b0, dt_q};
            num_q <= {num_q[62:0], 1'b1};
          end else begin
            rem_q <= shl;
            num_q <= {num_q[62:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
        end
        S_VSAT: begin
          cnt_q <= '0;
          if (sel_q) angv_q <= sat_v;
          else lin_q <= sat_v;
          sel_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_x_q   <= x_acc_q;
      o_y_q   <= y_acc_q;
      o_h_q   <= ang_acc_q;
      o_lin_q <= lin_q;
      o_ang_q <= angv_q;
      o_vv_q  <= (dt_q != '0);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pos_x_o            = o_x_q;
  assign pos_y_o            = o_y_q;
  assign heading_o          = o_h_q;
  assign linear_velocity_o  = o_lin_q;
  assign angular_velocity_o = o_ang_q;
  assign velocity_valid_o   = o_vv_q;

endmodule

>>> design/ddo_checker.sv
// Port-level checker for the odometry unit, bound to the top level.
`include "differential_drive_odometry_unit_defines.svh"
module ddo_checker
  import ddo_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pos_x_o,
  input logic [31:0] linear_velocity_o,
  input logic [31:0] angular_velocity_o,
  input logic        velocity_valid_o
);

  // hold a stalled result
  `DDO_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `DDO_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(pos_x_o), "stalled payload moved")
  // go busy after each accepted transaction
  `DDO_ASSERT(a_busy, in_valid_i && !in_stall_o |=> in_stall_o, "not busy after accept")
  // invalid velocity reads as zero
  `DDO_ASSERT(a_vel_zero, out_valid_o && !velocity_valid_o |->
      (linear_velocity_o == '0) && (angular_velocity_o == '0), "velocity not cleared")
  // a new result only comes from a sample in work
  `DDO_ASSERT(a_res_src, $rose(out_valid_o) |-> $past(in_stall_o), "result with no work")

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .pos_x_o            (pos_x_o),
  .linear_velocity_o  (linear_velocity_o),
  .angular_velocity_o (angular_velocity_o),
  .velocity_valid_o   (velocity_valid_o)
);
